[sv/upd_pkg.sv]
// Shared types, character codes and helper functions for the URI decode/normalize core.
`default_nettype none

package upd_pkg;

    localparam int UPD_QUEUE_DEPTH = 4;
    localparam int UPD_MAX_SYM     = 3;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_PCT    = 8'h25;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_DIG_LO = 8'h30;
    localparam logic [7:0] CH_DIG_HI = 8'h39;
    localparam logic [7:0] CH_UC_A   = 8'h41;
    localparam logic [7:0] CH_UC_F   = 8'h46;
    localparam logic [7:0] CH_LC_A   = 8'h61;
    localparam logic [7:0] CH_LC_F   = 8'h66;
    localparam logic [7:0] CH_W      = 8'h57;
    localparam logic [7:0] CH_CASE   = 8'h20;

    typedef struct packed {
        logic [UPD_MAX_SYM-1:0][7:0] sym;
        logic [1:0]                  cnt;
        logic                        last;
    } t_bundle;

    function automatic logic is_hex(input logic [7:0] c);
        return ((c >= CH_DIG_LO) && (c <= CH_DIG_HI)) ||
               ((c >= CH_LC_A) && (c <= CH_LC_F)) ||
               ((c >= CH_UC_A) && (c <= CH_UC_F));
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [7:0] v;
        if ((c >= CH_DIG_LO) && (c <= CH_DIG_HI)) begin
            v = c - CH_DIG_LO;
        end else begin
            v = (c | CH_CASE) - CH_W;
        end
        return v[3:0];
    endfunction

    function automatic logic is_sep(input logic [7:0] c);
        return (c == CH_SLASH) || (c == CH_BSLASH);
    endfunction

endpackage

`default_nettype wire

[sv/upd_front.sv]
// Front end: percent-decodes raw URI bytes and bundles each non-empty or final item.
`default_nettype none

module upd_front (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_valid,
    input  wire logic             i_cfg_data,
    input  wire logic             i_valid,
    input  wire logic [7:0]       i_data,
    input  wire logic             i_last,
    output logic                  o_ready,
    input  wire logic             i_q_full,
    output logic                  o_push,
    output upd_pkg::t_bundle      o_bundle
);

    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_PCT   = 2'd1;
    localparam logic [1:0] PH_DIGIT = 2'd2;

    logic       r_pas;
    logic [1:0] r_phase;
    logic [1:0] n_phase;
    logic [7:0] r_held;
    logic [7:0] n_held;
    logic       accept;

    logic [3:0][7:0] sym;
    logic [1:0]      cnt;
    logic            f_pct;
    logic [7:0]      f_d;
    logic [7:0]      dec;

    assign o_ready = !i_q_full;
    assign accept  = i_valid && o_ready;

    always_comb begin
        sym     = '0;
        cnt     = 2'd0;
        n_phase = r_phase;
        n_held  = r_held;
        f_pct   = (i_data == upd_pkg::CH_PCT);
        f_d     = (r_pas && (i_data == upd_pkg::CH_PLUS)) ? upd_pkg::CH_SPACE : i_data;
        dec     = {upd_pkg::hex_val(r_held), upd_pkg::hex_val(i_data)};
        unique case (r_phase)
            PH_PCT: begin
                if (upd_pkg::is_hex(i_data)) begin
                    n_held  = i_data;
                    n_phase = PH_DIGIT;
                end else begin
                    sym[cnt] = upd_pkg::CH_PCT;
                    cnt      = cnt + 2'd1;
                    if (!f_pct) begin
                        sym[cnt] = f_d;
                        cnt      = cnt + 2'd1;
                    end
                    n_phase = f_pct ? PH_PCT : PH_IDLE;
                end
            end
            PH_DIGIT: begin
                if (upd_pkg::is_hex(i_data)) begin
                    sym[cnt] = dec;
                    cnt      = cnt + 2'd1;
                    n_phase  = PH_IDLE;
                end else begin
                    sym[cnt] = upd_pkg::CH_PCT;
                    cnt      = cnt + 2'd1;
                    sym[cnt] = r_held;
                    cnt      = cnt + 2'd1;
                    if (!f_pct) begin
                        sym[cnt] = f_d;
                        cnt      = cnt + 2'd1;
                    end
                    n_phase = f_pct ? PH_PCT : PH_IDLE;
                end
            end
            default: begin
                if (!f_pct) begin
                    sym[cnt] = f_d;
                    cnt      = cnt + 2'd1;
                end
                n_phase = f_pct ? PH_PCT : PH_IDLE;
            end
        endcase
        if (i_last) begin
            if (n_phase == PH_PCT) begin
                sym[cnt] = upd_pkg::CH_PCT;
                cnt      = cnt + 2'd1;
            end else if (n_phase == PH_DIGIT) begin
                sym[cnt] = upd_pkg::CH_PCT;
                cnt      = cnt + 2'd1;
                sym[cnt] = n_held;
                cnt      = cnt + 2'd1;
            end
            n_phase = PH_IDLE;
            n_held  = 8'h00;
        end
    end

    assign o_push        = accept && ((cnt != 2'd0) || i_last);
    assign o_bundle.sym  = sym[upd_pkg::UPD_MAX_SYM-1:0];
    assign o_bundle.cnt  = cnt;
    assign o_bundle.last = i_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pas   <= 1'b0;
            r_phase <= PH_IDLE;
            r_held  <= 8'h00;
        end else begin
            if (i_cfg_valid) begin
                r_pas <= i_cfg_data;
            end
            if (accept) begin
                r_phase <= n_phase;
                r_held  <= n_held;
            end
        end
    end

endmodule

`default_nettype wire

[sv/upd_queue.sv]
// Short bundle queue between the decoder front end and the normalizer back end.
`default_nettype none

module upd_queue #(
    parameter int DEPTH = upd_pkg::UPD_QUEUE_DEPTH
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire upd_pkg::t_bundle  i_wdata,
    output logic                   o_full,
    input  wire logic              i_pop,
    output logic                   o_head_v,
    output upd_pkg::t_bundle       o_head
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_MAX = PW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_MAX = CW'(DEPTH);

    upd_pkg::t_bundle r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr;
    logic [PW-1:0]    r_rd_ptr;
    logic [CW-1:0]    r_count;
    logic             do_pop;

    assign o_full   = (r_count == CNT_MAX);
    assign o_head_v = (r_count != '0);
    assign o_head   = r_mem[r_rd_ptr];
    assign do_pop   = i_pop && o_head_v;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_MAX) ? '0 : r_wr_ptr + PW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_MAX) ? '0 : r_rd_ptr + PW'(1);
            end
            if (i_push && !do_pop) begin
                r_count <= r_count + CW'(1);
            end else if (!i_push && do_pop) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (!o_full || do_pop))
        else $error("push into full queue");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_MAX)
        else $error("queue count out of range");

endmodule

`default_nettype wire

[sv/upd_back.sv]
// Back end: normalizes decoded bytes, closes each URI and drives the output register.
`default_nettype none

module upd_back (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_head_v,
    input  wire upd_pkg::t_bundle  i_head,
    output logic                   o_pop,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output logic [7:0]             o_data,
    output logic                   o_has,
    output logic                   o_end
);

    logic       r_after, n_after;
    logic       r_dot, n_dot;
    logic       r_trunc, n_trunc;
    logic [1:0] r_idx, n_idx;
    logic       r_hold_v, n_hold_v;
    logic [7:0] r_hold_d, n_hold_d;
    logic       r_out_v;
    logic [7:0] r_out_d;
    logic       r_out_has;
    logic       r_out_end;

    logic       out_free;
    logic       ld;
    logic [7:0] ld_d;
    logic       ld_has;
    logic       ld_end;
    logic       emit;
    logic [7:0] emit_d;
    logic       adv;
    logic [7:0] c;

    assign out_free = !r_out_v || i_ready;

    always_comb begin
        unique case (r_idx)
            2'd0:    c = i_head.sym[0];
            2'd1:    c = i_head.sym[1];
            2'd2:    c = i_head.sym[2];
            default: c = upd_pkg::CH_NUL;
        endcase
    end

    always_comb begin
        n_after  = r_after;
        n_dot    = r_dot;
        n_trunc  = r_trunc;
        n_idx    = r_idx;
        n_hold_v = r_hold_v;
        n_hold_d = r_hold_d;
        o_pop    = 1'b0;
        ld       = 1'b0;
        ld_d     = 8'h00;
        ld_has   = 1'b1;
        ld_end   = 1'b0;
        emit     = 1'b0;
        emit_d   = 8'h00;
        adv      = 1'b0;
        if (i_head_v && out_free) begin
            if (r_idx != i_head.cnt) begin
                priority if (r_trunc) begin
                    adv = 1'b1;
                end else if (c == upd_pkg::CH_NUL) begin
                    emit    = r_dot;
                    emit_d  = upd_pkg::CH_DOT;
                    n_dot   = 1'b0;
                    n_after = 1'b0;
                    n_trunc = 1'b1;
                    adv     = 1'b1;
                end else if (r_after && r_dot) begin
                    n_dot = 1'b0;
                    if (c == upd_pkg::CH_DOT) begin
                        adv = 1'b1;
                    end else begin
                        emit    = 1'b1;
                        emit_d  = upd_pkg::CH_DOT;
                        n_after = 1'b0;
                    end
                end else if (r_after && upd_pkg::is_sep(c)) begin
                    adv = 1'b1;
                end else if (r_after && (c == upd_pkg::CH_DOT)) begin
                    n_dot = 1'b1;
                    adv   = 1'b1;
                end else begin
                    emit    = 1'b1;
                    emit_d  = c;
                    n_after = upd_pkg::is_sep(c);
                    adv     = 1'b1;
                end
            end else if (!r_trunc && r_dot) begin
                emit   = 1'b1;
                emit_d = upd_pkg::CH_DOT;
                n_dot  = 1'b0;
            end else begin
                ld       = 1'b1;
                ld_d     = r_hold_v ? r_hold_d : 8'h00;
                ld_has   = r_hold_v;
                ld_end   = 1'b1;
                n_hold_v = 1'b0;
                n_after  = 1'b0;
                n_dot    = 1'b0;
                n_trunc  = 1'b0;
                n_idx    = 2'd0;
                o_pop    = 1'b1;
            end
        end
        if (adv) begin
            if (((r_idx + 2'd1) == i_head.cnt) && !i_head.last) begin
                o_pop = 1'b1;
                n_idx = 2'd0;
            end else begin
                n_idx = r_idx + 2'd1;
            end
        end
        if (emit) begin
            if (i_head.last) begin
                n_hold_v = 1'b1;
                n_hold_d = emit_d;
                if (r_hold_v) begin
                    ld   = 1'b1;
                    ld_d = r_hold_d;
                end
            end else begin
                ld   = 1'b1;
                ld_d = emit_d;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_after  <= 1'b0;
            r_dot    <= 1'b0;
            r_trunc  <= 1'b0;
            r_idx    <= 2'd0;
            r_hold_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            r_after  <= n_after;
            r_dot    <= n_dot;
            r_trunc  <= n_trunc;
            r_idx    <= n_idx;
            r_hold_v <= n_hold_v;
            if (ld) begin
                r_out_v <= 1'b1;
            end else if (i_ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_hold_d <= n_hold_d;
        if (ld) begin
            r_out_d   <= ld_d;
            r_out_has <= ld_has;
            r_out_end <= ld_end;
        end
    end

    assign o_valid = r_out_v;
    assign o_data  = r_out_d;
    assign o_has   = r_out_has;
    assign o_end   = r_out_end;

    a_hold_in_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hold_v |-> (i_head_v && i_head.last))
        else $error("held item outside a final bundle");

    a_trunc_no_dot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_trunc |-> !r_dot)
        else $error("dot pending after truncation");

    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_head_v |-> (r_idx <= i_head.cnt))
        else $error("bundle index past count");

    a_idx_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_head_v |-> (r_idx == 2'd0))
        else $error("bundle index nonzero with empty queue");

endmodule

`default_nettype wire

[sv/uri_percent_decode_normalize_core.sv]
// Top level of the URI percent-decode and path-normalize core.
// Raw URI bytes enter one per cycle on the slave stream while the queue has room; tlast marks
// the final byte of a URI. The front end decodes '%' escapes (and '+' to space when the config
// bit is set) and queues a bundle of up to three decoded bytes for each item that yields a
// byte or ends the URI, in a QUEUE_DEPTH-entry queue. The back end normalizes one decoded byte
// per cycle while the output register is free; closing a URI and flushing a held '.' each take
// an extra step; ordinary bytes sustain one item per cycle unless the output stalls. Each URI
// closes with a result whose tlast is set, or with an empty result (tuser 0) when the final
// item yields no byte. The queue lets input be taken while a finished result waits.
`default_nettype none

module uri_percent_decode_normalize_core #(
    parameter int QUEUE_DEPTH = upd_pkg::UPD_QUEUE_DEPTH
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_valid,
    output logic            o_cfg_ready,
    input  wire logic       i_cfg_data,       // plus_as_space
    input  wire logic       i_s_tvalid,
    output logic            o_s_tready,
    input  wire logic [7:0] i_s_tdata,        // [7:0] in_byte
    input  wire logic       i_s_tlast,        // last_byte
    output logic            o_m_tvalid,
    input  wire logic       i_m_tready,
    output logic [7:0]      o_m_tdata,        // [7:0] out_byte
    output logic            o_m_tuser,        // has_byte
    output logic            o_m_tlast         // end_of_uri
);

    upd_pkg::t_bundle push_data;
    upd_pkg::t_bundle head;
    logic             push;
    logic             q_full;
    logic             head_v;
    logic             pop;

    assign o_cfg_ready = 1'b1;

    upd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_s_tvalid),
        .i_data      (i_s_tdata),
        .i_last      (i_s_tlast),
        .o_ready     (o_s_tready),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_bundle    (push_data)
    );

    upd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_wdata  (push_data),
        .o_full   (q_full),
        .i_pop    (pop),
        .o_head_v (head_v),
        .o_head   (head)
    );

    upd_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head_v (head_v),
        .i_head   (head),
        .o_pop    (pop),
        .o_valid  (o_m_tvalid),
        .i_ready  (i_m_tready),
        .o_data   (o_m_tdata),
        .o_has    (o_m_tuser),
        .o_end    (o_m_tlast)
    );

endmodule

`default_nettype wire

[dv/tb_uri_percent_decode_normalize_core.sv]
// Self-checking testbench for the URI percent-decode and path-normalize core.
`timescale 1ns / 1ps

module tb_uri_percent_decode_normalize_core;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 32;
    localparam int RANDOM_ITEMS = 60;

    localparam logic [1:0] ESC_IDLE  = 2'd0;
    localparam logic [1:0] ESC_PCT   = 2'd1;
    localparam logic [1:0] ESC_DIGIT = 2'd2;

    typedef struct packed {
        logic [7:0] data;
        logic       has;
        logic       last;
    } t_uri_out;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       typed;
        t_uri_out   want;
    } t_uri_row;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_cfg_valid = 1'b0;
    logic       i_cfg_data  = 1'b0;
    logic       i_s_tvalid  = 1'b0;
    logic [7:0] i_s_tdata   = 8'h00;
    logic       i_s_tlast   = 1'b0;
    logic       i_m_tready  = 1'b0;
    logic       o_cfg_ready;
    logic       o_s_tready;
    logic       o_m_tvalid;
    logic [7:0] o_m_tdata;
    logic       o_m_tuser;
    logic       o_m_tlast;

    uri_percent_decode_normalize_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tlast   (i_s_tlast),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // decoder and normalizer state
    logic       plus_space_cfg;
    logic [1:0] esc_phase;
    logic [7:0] held_hex;
    logic       skip_sep;
    logic       dot_held;
    logic       cut_off;

    t_uri_out   decoded_q[$];
    t_uri_out   step_q[$];

    int errors       = 0;
    int cycles       = 0;
    int live_items   = 0;
    int uris_sent    = 0;
    int results_seen = 0;
    int s_gap_pct    = 17;
    int m_stall_pct  = 62;

    t_uri_row dir_rows [0:27] = '{
        '{"A",               1'b1, 1'b1, '{"A",             1'b1, 1'b1}},
        '{upd_pkg::CH_NUL,   1'b1, 1'b1, '{upd_pkg::CH_NUL,  1'b0, 1'b1}},
        '{8'hFF,             1'b1, 1'b1, '{8'hFF,            1'b1, 1'b1}},
        '{upd_pkg::CH_PLUS,  1'b1, 1'b1, '{upd_pkg::CH_PLUS, 1'b1, 1'b1}},
        '{upd_pkg::CH_PCT,    1'b0, 1'b0, '0},
        '{"4",                1'b0, 1'b0, '0},
        '{"a",                1'b0, 1'b0, '0},
        '{upd_pkg::CH_SLASH,  1'b0, 1'b0, '0},
        '{upd_pkg::CH_SLASH,  1'b0, 1'b0, '0},
        '{upd_pkg::CH_DOT,    1'b0, 1'b0, '0},
        '{upd_pkg::CH_DOT,    1'b0, 1'b0, '0},
        '{upd_pkg::CH_BSLASH, 1'b0, 1'b0, '0},
        '{upd_pkg::CH_DOT,    1'b0, 1'b0, '0},
        '{"x",                1'b0, 1'b0, '0},
        '{upd_pkg::CH_PCT,    1'b0, 1'b0, '0},
        '{"G",                1'b0, 1'b0, '0},
        '{upd_pkg::CH_PCT,    1'b0, 1'b0, '0},
        '{"F",                1'b0, 1'b0, '0},
        '{upd_pkg::CH_SLASH,  1'b0, 1'b0, '0},
        '{upd_pkg::CH_PCT,    1'b0, 1'b0, '0},
        '{"0",                1'b0, 1'b0, '0},
        '{"0",                1'b0, 1'b0, '0},
        '{"q",                1'b0, 1'b0, '0},
        '{upd_pkg::CH_SLASH,  1'b1, 1'b0, '0},
        '{upd_pkg::CH_PCT,    1'b0, 1'b0, '0},
        '{"e",                1'b1, 1'b0, '0},
        '{upd_pkg::CH_SLASH,  1'b0, 1'b0, '0},
        '{upd_pkg::CH_DOT,    1'b1, 1'b0, '0}
    };

    function automatic logic [4:0] hex_nibble(input logic [7:0] c);
        logic [7:0] low;
        low = c | upd_pkg::CH_CASE;
        if (c >= upd_pkg::CH_DIG_LO && c <= upd_pkg::CH_DIG_HI) begin
            return {1'b1, c[3:0]};
        end else if (low >= upd_pkg::CH_LC_A && low <= upd_pkg::CH_LC_F && !(c >= 8'h80)) begin
            return {1'b1, 4'(c[2:0] + 4'd9)};
        end
        return 5'b0;
    endfunction

    function automatic logic is_separator(input logic [7:0] c);
        return c == upd_pkg::CH_SLASH || c == upd_pkg::CH_BSLASH;
    endfunction

    function automatic void emit(input logic [7:0] c);
        step_q.push_back('{c, 1'b1, 1'b0});
    endfunction

    function automatic void normalize_char(input logic [7:0] c);
        if (cut_off) return;
        if (c == upd_pkg::CH_NUL) begin
            if (dot_held) emit(upd_pkg::CH_DOT);
            dot_held = 1'b0;
            skip_sep = 1'b0;
            cut_off  = 1'b1;
            return;
        end
        if (skip_sep) begin
            if (dot_held) begin
                dot_held = 1'b0;
                if (c == upd_pkg::CH_DOT) return;
                emit(upd_pkg::CH_DOT);
                skip_sep = 1'b0;
            end else if (is_separator(c)) begin
                return;
            end else if (c == upd_pkg::CH_DOT) begin
                dot_held = 1'b1;
                return;
            end else begin
                skip_sep = 1'b0;
                emit(c);
                return;
            end
        end
        emit(c);
        if (is_separator(c)) skip_sep = 1'b1;
    endfunction

    function automatic void decode_plain(input logic [7:0] b);
        if (b == upd_pkg::CH_PCT) begin
            esc_phase = ESC_PCT;
        end else if (plus_space_cfg && b == upd_pkg::CH_PLUS) begin
            normalize_char(upd_pkg::CH_SPACE);
        end else begin
            normalize_char(b);
        end
    endfunction

    // fill step_q with the results one raw byte causes
    function automatic void predict_uri_byte(input logic [7:0] b, input logic last);
        logic [4:0] nib;
        logic [4:0] first;
        step_q.delete();
        nib = hex_nibble(b);
        if (!cut_off) begin
            case (esc_phase)
                ESC_PCT: begin
                    if (nib[4]) begin
                        held_hex  = b;
                        esc_phase = ESC_DIGIT;
                    end else begin
                        esc_phase = ESC_IDLE;
                        normalize_char(upd_pkg::CH_PCT);
                        decode_plain(b);
                    end
                end
                ESC_DIGIT: begin
                    esc_phase = ESC_IDLE;
                    if (nib[4]) begin
                        first = hex_nibble(held_hex);
                        normalize_char({first[3:0], nib[3:0]});
                    end else begin
                        normalize_char(upd_pkg::CH_PCT);
                        normalize_char(held_hex);
                        decode_plain(b);
                    end
                end
                default: begin
                    esc_phase = ESC_IDLE;
                    decode_plain(b);
                end
            endcase
        end
        if (last) begin
            if (!cut_off) begin
                if (esc_phase == ESC_PCT) begin
                    normalize_char(upd_pkg::CH_PCT);
                end else if (esc_phase == ESC_DIGIT) begin
                    normalize_char(upd_pkg::CH_PCT);
                    normalize_char(held_hex);
                end
                if (dot_held) emit(upd_pkg::CH_DOT);
            end
            if (step_q.size() == 0) begin
                step_q.push_back('{upd_pkg::CH_NUL, 1'b0, 1'b1});
            end else begin
                step_q[step_q.size()-1].last = 1'b1;
            end
            esc_phase = ESC_IDLE;
            held_hex  = 8'h00;
            skip_sep  = 1'b0;
            dot_held  = 1'b0;
            cut_off   = 1'b0;
        end
    endfunction

    task automatic report_mismatch(input string field, input logic [7:0] got,
                                   input logic [7:0] want);
        $display("[%0d] mismatch on %s: got 0x%02h, want 0x%02h", cycles, field, got, want);
        errors++;
    endtask

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results pending", cycles,
                     decoded_q.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    // receiver: stall at random, check every accepted item
    always @(posedge i_clk) begin
        t_uri_out want;
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                results_seen++;
                if (decoded_q.size() == 0) begin
                    report_mismatch("unexpected item", o_m_tdata, 8'h00);
                end else begin
                    want = decoded_q.pop_front();
                    if (o_m_tdata !== want.data) report_mismatch("tdata", o_m_tdata, want.data);
                    if (o_m_tuser !== want.has) begin
                        report_mismatch("tuser", {7'd0, o_m_tuser}, {7'd0, want.has});
                    end
                    if (o_m_tlast !== want.last) begin
                        report_mismatch("tlast", {7'd0, o_m_tlast}, {7'd0, want.last});
                    end
                end
            end
            i_m_tready <= ($urandom_range(0, 99) >= m_stall_pct);
        end
    end

    task automatic push_byte(input logic [7:0] b, input logic last, input logic typed,
                             input t_uri_out want);
        logic was_live;
        if ($urandom_range(0, 99) < s_gap_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(0, 99) < s_gap_pct) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= b;
        i_s_tlast  <= last;
        do @(posedge i_clk); while (!o_s_tready);
        was_live = !cut_off;
        predict_uri_byte(b, last);
        if (typed) begin
            decoded_q.push_back(want);
        end else begin
            foreach (step_q[k]) decoded_q.push_back(step_q[k]);
        end
        if (was_live) live_items++;
        if (last) uris_sent++;
    endtask

    task automatic drain_results();
        i_s_tvalid <= 1'b0;
        while (decoded_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_plus_space(input logic value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid    <= 1'b0;
        plus_space_cfg  = value;
    endtask

    function automatic logic [7:0] rand_hex_char();
        int v;
        v = $urandom_range(0, 21);
        if (v < 10) return upd_pkg::CH_DIG_LO + 8'(v);
        if (v < 16) return upd_pkg::CH_LC_A + 8'(v - 10);
        return upd_pkg::CH_UC_A + 8'(v - 16);
    endfunction

    // mostly path-like URIs with escapes, some pure noise
    task automatic send_random_uri();
        logic [7:0] uri[$];
        int         len;
        int         pick;
        logic       noise;
        len   = $urandom_range(1, 10);
        noise = ($urandom_range(0, 9) == 0);
        while (uri.size() < len) begin
            pick = noise ? 100 : $urandom_range(0, 99);
            if (pick < 15) begin
                uri.push_back(upd_pkg::CH_SLASH);
            end else if (pick < 22) begin
                uri.push_back(upd_pkg::CH_BSLASH);
            end else if (pick < 36) begin
                uri.push_back(upd_pkg::CH_DOT);
            end else if (pick < 50) begin
                uri.push_back(upd_pkg::CH_PCT);
                uri.push_back(rand_hex_char());
                if ($urandom_range(0, 5) == 0) uri.push_back(8'($urandom_range(0, 255)));
                else uri.push_back(rand_hex_char());
            end else if (pick < 55) begin
                uri.push_back(upd_pkg::CH_PLUS);
            end else if (pick < 58) begin
                uri.push_back(upd_pkg::CH_PCT);
            end else if (pick < 60) begin
                uri.push_back(upd_pkg::CH_NUL);
            end else if (pick < 62) begin
                uri.push_back(upd_pkg::CH_PCT);
                uri.push_back(upd_pkg::CH_DIG_LO);
                uri.push_back(upd_pkg::CH_DIG_LO);
            end else if (pick < 85) begin
                uri.push_back(upd_pkg::CH_LC_A + 8'($urandom_range(0, 25)));
            end else begin
                uri.push_back(8'($urandom_range(0, 255)));
            end
        end
        foreach (uri[k]) push_byte(uri[k], k == uri.size() - 1, 1'b0, '0);
    endtask

    task automatic run_random(input int count);
        int stop_at;
        stop_at = live_items + count;
        while (live_items < stop_at) send_random_uri();
    endtask

    initial begin
        plus_space_cfg = 1'b0;
        esc_phase      = ESC_IDLE;
        held_hex       = 8'h00;
        skip_sep       = 1'b0;
        dot_held       = 1'b0;
        cut_off        = 1'b0;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_plus_space(1'b0);
        foreach (dir_rows[r]) begin
            push_byte(dir_rows[r].data, dir_rows[r].last, dir_rows[r].typed, dir_rows[r].want);
        end
        drain_results();

        write_plus_space(1'b1);
        push_byte(upd_pkg::CH_PLUS, 1'b1, 1'b1, '{upd_pkg::CH_SPACE, 1'b1, 1'b1});
        run_random(RANDOM_ITEMS / 3);
        drain_results();

        s_gap_pct   = 62;
        m_stall_pct = 17;
        write_plus_space(1'b0);
        run_random(RANDOM_ITEMS / 6);
        drain_results();
        run_random(RANDOM_ITEMS / 6);
        drain_results();

        s_gap_pct   = 0;
        m_stall_pct = 0;
        write_plus_space(1'b1);
        run_random(RANDOM_ITEMS / 3);
        drain_results();

        $display("Sent %0d URIs (%0d live bytes), checked %0d output items", uris_sent,
                 live_items, results_seen);
        $display("plus_as_space exercised at 0 and 1, three sender/receiver stall mixes");
        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("%0d mismatches", errors);
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

[files.f]
sv/upd_pkg.sv
sv/upd_front.sv
sv/upd_queue.sv
sv/upd_back.sv
sv/uri_percent_decode_normalize_core.sv
dv/tb_uri_percent_decode_normalize_core.sv
